// ===== src/pts_pkg.sv =====
// Shared types and constants for the periodic timer slot table.
`default_nettype none
package pts_pkg;

  localparam int SLOTS_DEFAULT = 8;
  localparam int OWNER_W       = 8;
  localparam int PERIOD_W      = 16;
  localparam int COUNT_W       = 11;
  localparam int BURST_W       = 6;
  localparam int STATUS_W      = 3;

  localparam int TICKS_PER_SEC = 20;
  localparam int MS_PER_SEC    = 1000;
  localparam int MS_PER_TICK   = MS_PER_SEC / TICKS_PER_SEC;

  // period / MS_PER_TICK as (period * RECIP) >> RECIP_SHIFT, exact over 16-bit periods
  localparam int RECIP_SHIFT = 22;
  localparam int RECIP_W     = 17;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'((2 ** RECIP_SHIFT + MS_PER_TICK - 1) / MS_PER_TICK);
  localparam int PROD_W = PERIOD_W + RECIP_W;

  typedef enum logic [1:0] {
    OP_TICK     = 2'd0,
    OP_REGISTER = 2'd1,
    OP_REMOVE   = 2'd2
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK          = 3'd0,
    STAT_DUPLICATE   = 3'd1,
    STAT_NOT_FOUND   = 3'd2,
    STAT_FULL        = 3'd3,
    STAT_ZERO_PERIOD = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    PASS_TICK  = 2'd0,
    PASS_FIND  = 2'd1,
    PASS_CLAIM = 2'd2
  } pass_t;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_SWEEP = 2'd1,
    S_REPLY = 2'd2
  } state_t;

  typedef struct packed {
    pass_t               pass;
    logic                remove;
    logic [OWNER_W-1:0]  owner;
    logic [COUNT_W-1:0]  reload;
    logic [BURST_W-1:0]  burst;
  } cmd_t;

  typedef struct packed {
    logic here;
    logic flag;
  } link_t;

  typedef struct packed {
    logic                pend;
    logic [OWNER_W-1:0]  owner;
    logic [BURST_W-1:0]  burst;
  } cell_stat_t;

endpackage
`default_nettype wire

// ===== src/pts_cell.sv =====
// One timer slot cell of the chain; the sweep token and its flag pass through it.
`default_nettype none
module pts_cell
  import pts_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       advance,
  input  wire cmd_t       cmd,
  input  wire link_t      prev,
  output link_t           link,
  output cell_stat_t      stat
);

  logic                used;
  logic [OWNER_W-1:0]  owner;
  logic [COUNT_W-1:0]  countdown;
  logic [COUNT_W-1:0]  reload;
  logic [BURST_W-1:0]  burst;
  logic                here;
  logic                flag;

  logic match;
  logic pend;
  logic step;

  assign match = used && (owner == cmd.owner);
  assign pend  = used && (countdown == COUNT_W'(1));
  assign step  = here && advance;

  always_comb begin
    link.here = here;
    case (cmd.pass)
      PASS_FIND:  link.flag = flag | match;
      PASS_CLAIM: link.flag = flag | !used;
      default:    link.flag = flag;
    endcase
  end

  assign stat.pend  = pend;
  assign stat.owner = owner;
  assign stat.burst = burst;

  always_ff @(posedge clk) begin
    if (rst) begin
      here <= 1'b0;
      flag <= 1'b0;
    end else if (advance) begin
      here <= prev.here;
      flag <= prev.flag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= 1'b0;
    end else if (step) begin
      case (cmd.pass)
        PASS_FIND: begin
          if (cmd.remove && match) used <= 1'b0;
        end
        PASS_CLAIM: begin
          if (!used && !flag) used <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      case (cmd.pass)
        PASS_TICK: begin
          if (used) countdown <= pend ? reload : countdown - COUNT_W'(1);
        end
        PASS_CLAIM: begin
          if (!used && !flag) begin
            owner     <= cmd.owner;
            countdown <= cmd.reload;
            reload    <= cmd.reload;
            burst     <= cmd.burst;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== src/periodic_timer_slot_table.sv =====
// Top level of the periodic timer slot table: command control, cell chain and result register.
//
// Input channel s_axis: one transaction is one command (tick, register owner, remove owner).
// Output channel m_axis: fire results (tuser 0) and command status results (tuser 1);
// tlast marks the final result caused by a command.
// A token walks the chain of SLOTS cells, one cell per cycle while no fire waits on
// the output register, with a flag that collects the match or free-slot answer along the way.
// Tick: one fire result per expiring slot in slot order.
// Remove: one walk; the status result follows it.
// Register: one walk for the duplicate check and, if the owner is new and the period
// is nonzero, a second walk that claims the lowest free slot; the status result
// follows the last walk. An unused opcode is dropped on accept.
// The next command is taken once the current walk and its status result are done;
// a finished result may still wait in the output register.
// Reset clears every slot's used bit, the token and the output register's valid bit.
// When the receiver stalls, a tick walk halts at the firing cell until the
// output register frees, so no fire is lost.
`default_nettype none
module periodic_timer_slot_table
  import pts_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // opcode[1:0], owner_id[9:2], period_ms[25:10]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,  // owner_out[7:0], burst[13:8], status[16:14]
  output logic             m_axis_tuser,  // kind
  output logic             m_axis_tlast
);

  state_t state;
  state_t state_next;
  pass_t  pass_q;
  pass_t  pass_next;

  opcode_t              op_q;
  logic [OWNER_W-1:0]   owner_q;
  logic [PERIOD_W-1:0]  period_q;
  logic [PROD_W-1:0]    prod_q;
  status_t              status_q;
  status_t              status_next;

  logic                 out_valid;
  logic                 out_kind;
  logic [OWNER_W-1:0]   out_owner;
  logic [BURST_W-1:0]   out_burst;
  status_t              out_status;
  logic                 out_last;

  logic [1:0]           in_opcode;
  logic [OWNER_W-1:0]   in_owner;
  logic [PERIOD_W-1:0]  in_period;

  logic accept;
  logic start;
  logic advance;
  logic out_free;
  logic fire_now;
  logic fire_last;
  logic chain_done;
  logic load_fire;
  logic load_stat;
  logic [OWNER_W-1:0] fire_owner;
  logic [BURST_W-1:0] fire_burst;
  logic [COUNT_W-1:0] rel;
  logic [BURST_W-1:0] new_burst;

  cmd_t       cmd;
  link_t      links [SLOTS+1];
  cell_stat_t stats [SLOTS];
  logic [SLOTS:0] later;

  function automatic logic [BURST_W-1:0] short_burst(input logic [PERIOD_W-1:0] p);
    logic [BURST_W-1:0] b;
    b = BURST_W'(1);
    if (p < PERIOD_W'(MS_PER_TICK)) begin
      case (p[5:0]) inside
        6'd1:      b = 6'd50;
        6'd2:      b = 6'd25;
        6'd3:      b = 6'd16;
        6'd4:      b = 6'd12;
        6'd5:      b = 6'd10;
        6'd6:      b = 6'd8;
        6'd7:      b = 6'd7;
        6'd8:      b = 6'd6;
        [6'd9:6'd10]:  b = 6'd5;
        [6'd11:6'd12]: b = 6'd4;
        [6'd13:6'd16]: b = 6'd3;
        [6'd17:6'd25]: b = 6'd2;
        default:   b = 6'd1;
      endcase
    end
    return b;
  endfunction

  assign in_opcode = s_axis_tdata[1:0];
  assign in_owner  = s_axis_tdata[9:2];
  assign in_period = s_axis_tdata[25:10];

  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid || m_axis_tready;

  assign rel       = prod_q[RECIP_SHIFT +: COUNT_W];
  assign new_burst = short_burst(period_q);

  assign cmd.pass   = pass_q;
  assign cmd.remove = (op_q == OP_REMOVE);
  assign cmd.owner  = owner_q;
  assign cmd.reload = (rel == '0) ? COUNT_W'(1) : rel;
  assign cmd.burst  = new_burst;

  assign links[0].here = start;
  assign links[0].flag = 1'b0;

  genvar gi;
  generate
    for (gi = 0; gi < SLOTS; gi++) begin : g_cell
      pts_cell u_cell (
        .clk     (clk),
        .rst     (rst),
        .advance (advance),
        .cmd     (cmd),
        .prev    (links[gi]),
        .link    (links[gi+1]),
        .stat    (stats[gi])
      );
      assign later[gi] = stats[gi].pend | later[gi+1];
    end
  endgenerate
  assign later[SLOTS] = 1'b0;

  always_comb begin
    fire_now   = 1'b0;
    fire_last  = 1'b0;
    fire_owner = '0;
    fire_burst = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (links[i+1].here && stats[i].pend) begin
        fire_now   = 1'b1;
        fire_last  = !later[i+1];
        fire_owner = stats[i].owner;
        fire_burst = stats[i].burst;
      end
    end
    if (pass_q != PASS_TICK) fire_now = 1'b0;
  end

  assign advance    = !(fire_now && !out_free);
  assign chain_done = links[SLOTS].here && advance;

  always_comb begin
    state_next  = state;
    pass_next   = pass_q;
    status_next = status_q;
    start       = 1'b0;
    load_fire   = 1'b0;
    load_stat   = 1'b0;
    case (state)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          case (in_opcode)
            OP_TICK: begin
              start      = 1'b1;
              pass_next  = PASS_TICK;
              state_next = S_SWEEP;
            end
            OP_REGISTER, OP_REMOVE: begin
              start      = 1'b1;
              pass_next  = PASS_FIND;
              state_next = S_SWEEP;
            end
            default: begin
            end
          endcase
        end
      end
      S_SWEEP: begin
        if (fire_now && out_free) load_fire = 1'b1;
        if (chain_done) begin
          case (pass_q)
            PASS_TICK: state_next = S_IDLE;
            PASS_FIND: begin
              if (op_q == OP_REMOVE) begin
                status_next = links[SLOTS].flag ? STAT_OK : STAT_NOT_FOUND;
                state_next  = S_REPLY;
              end else if (links[SLOTS].flag) begin
                status_next = STAT_DUPLICATE;
                state_next  = S_REPLY;
              end else if (period_q == '0) begin
                status_next = STAT_ZERO_PERIOD;
                state_next  = S_REPLY;
              end else begin
                start     = 1'b1;
                pass_next = PASS_CLAIM;
              end
            end
            PASS_CLAIM: begin
              status_next = links[SLOTS].flag ? STAT_OK : STAT_FULL;
              state_next  = S_REPLY;
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_REPLY: begin
        if (out_free) begin
          load_stat  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      pass_q <= PASS_TICK;
    end else begin
      state  <= state_next;
      pass_q <= pass_next;
    end
  end

  always_ff @(posedge clk) begin
    status_q <= status_next;
    prod_q   <= PROD_W'(period_q) * PROD_W'(RECIP);
    if (accept) begin
      op_q     <= opcode_t'(in_opcode);
      owner_q  <= in_owner;
      period_q <= in_period;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_fire || load_stat) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_fire) begin
      out_kind   <= 1'b0;
      out_owner  <= fire_owner;
      out_burst  <= fire_burst;
      out_status <= STAT_OK;
      out_last   <= fire_last;
    end else if (load_stat) begin
      out_kind   <= 1'b1;
      out_owner  <= owner_q;
      out_burst  <= '0;
      out_status <= status_q;
      out_last   <= 1'b1;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_kind;
  assign m_axis_tlast  = out_last;
  assign m_axis_tdata  = {7'd0, out_status, out_burst, out_owner};

endmodule
`default_nettype wire
